>>> hw/rtl/imsc_pkg.sv
// Shared types and constants for the image scaler core.
// No dependencies; imported by every module of the block.
package imsc_pkg;

    // Item kinds
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_REQ  = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_SRC_W  = 3'd0;
    localparam logic [2:0] CFG_SRC_H  = 3'd1;
    localparam logic [2:0] CFG_TGT_L  = 3'd2;
    localparam logic [2:0] CFG_TGT_T  = 3'd3;
    localparam logic [2:0] CFG_TGT_W  = 3'd4;
    localparam logic [2:0] CFG_TGT_H  = 3'd5;
    localparam logic [2:0] CFG_CNV_W  = 3'd6;
    localparam logic [2:0] CFG_CNV_H  = 3'd7;

    // Blend and divider constants: weight of one, rounding half and numerator width
    localparam logic [8:0]  FRAC_ONE   = 9'd256;
    localparam logic [25:0] ROUND_HALF = 26'd32768;
    localparam int          NUM_W      = 28;

    // Item carried alongside the division pipeline
    typedef struct packed {
        logic        kind;
        logic        bil;
        logic        act;
        logic [11:0] col;
        logic [11:0] row;
        logic [31:0] pix;
        logic [6:0]  sw;
        logic [6:0]  sh;
    } item_t;

    // Four fetched neighbors and weights for the blend unit
    typedef struct packed {
        logic        near;
        logic [7:0]  fx;
        logic [7:0]  fy;
        logic [31:0] p00;
        logic [31:0] p10;
        logic [31:0] p01;
        logic [31:0] p11;
        logic [11:0] col;
        logic [11:0] row;
    } blend_req_t;

    // Finished result word
    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic [31:0] color;
    } pix_out_t;

endpackage

>>> hw/rtl/imsc_div.sv
// Pipelined restoring divider, one quotient bit per stage, two axes in parallel.
// Depends on imsc_pkg; instantiated by image_scaler_nearest_bilinear_core.
module imsc_div
    import imsc_pkg::*;
#(
    parameter int QW = 15,
    parameter int NW = 28,
    parameter int DW = 13,
    parameter int PW = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [NW-1:0] in_nx,
    input  logic [NW-1:0] in_ny,
    input  logic [DW-1:0] den_x,
    input  logic [DW-1:0] den_y,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [QW-1:0] out_qx,
    output logic [QW-1:0] out_qy,
    output logic [PW-1:0] out_pay
);

    logic          v_reg   [QW];
    logic [QW-1:0] lox_reg [QW];
    logic [QW-1:0] loy_reg [QW];
    logic [DW-1:0] rx_reg  [QW];
    logic [DW-1:0] ry_reg  [QW];
    logic [QW-1:0] qx_reg  [QW];
    logic [QW-1:0] qy_reg  [QW];
    logic [PW-1:0] pay_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic          iv;
        logic [QW-1:0] ilox, iloy, iqx, iqy;
        logic [DW-1:0] irx, iry, nrx, nry;
        logic [PW-1:0] ipay;
        logic [DW:0]   tx, ty;
        logic          gex, gey;

        if (k == 0) begin : g_first
            assign iv   = in_valid;
            assign ilox = in_nx[QW-1:0];
            assign iloy = in_ny[QW-1:0];
            assign irx  = DW'(in_nx >> QW);
            assign iry  = DW'(in_ny >> QW);
            assign iqx  = '0;
            assign iqy  = '0;
            assign ipay = in_pay;
        end else begin : g_next
            assign iv   = v_reg[k-1];
            assign ilox = lox_reg[k-1];
            assign iloy = loy_reg[k-1];
            assign irx  = rx_reg[k-1];
            assign iry  = ry_reg[k-1];
            assign iqx  = qx_reg[k-1];
            assign iqy  = qy_reg[k-1];
            assign ipay = pay_reg[k-1];
        end

        // Shift in the next numerator bit and try the subtract
        assign tx  = {irx, ilox[QW-1-k]};
        assign ty  = {iry, iloy[QW-1-k]};
        assign gex = tx >= {1'b0, den_x};
        assign gey = ty >= {1'b0, den_y};
        assign nrx = gex ? DW'(tx - {1'b0, den_x}) : DW'(tx);
        assign nry = gey ? DW'(ty - {1'b0, den_y}) : DW'(ty);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= iv;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                lox_reg[k] <= ilox;
                loy_reg[k] <= iloy;
                rx_reg[k]  <= nrx;
                ry_reg[k]  <= nry;
                qx_reg[k]  <= {iqx[QW-2:0], gex};
                qy_reg[k]  <= {iqy[QW-2:0], gey};
                pay_reg[k] <= ipay;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_qx    = qx_reg[QW-1];
    assign out_qy    = qy_reg[QW-1];
    assign out_pay   = pay_reg[QW-1];

endmodule

>>> hw/rtl/imsc_blend.sv
// Two-stage per-channel bilinear blend with round half up; nearest passes the word.
// Depends on imsc_pkg; instantiated by image_scaler_nearest_bilinear_core.
module imsc_blend
    import imsc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       en,
    input  logic       in_valid,
    input  blend_req_t in_req,
    output logic       out_valid,
    output pix_out_t   out_pix
);

    logic        b1v_reg;
    logic        b1near_reg;
    logic [31:0] b1word_reg;
    logic [7:0]  b1fy_reg;
    logic [11:0] b1col_reg, b1row_reg;
    logic [16:0] top_reg [3];
    logic [16:0] bot_reg [3];
    logic [16:0] top_next [3];
    logic [16:0] bot_next [3];
    logic [7:0]  ch [3];
    logic [25:0] vsum [3];
    logic [8:0]  wx, wy;

    logic     b2v_reg;
    pix_out_t b2_reg;
    pix_out_t b2_next;

    // Horizontal and vertical weights
    assign wx = FRAC_ONE - {1'b0, in_req.fx};
    assign wy = FRAC_ONE - {1'b0, b1fy_reg};

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            top_next[c] = 17'(in_req.p00[8*c +: 8] * wx)
                        + 17'(in_req.p10[8*c +: 8] * {1'b0, in_req.fx});
            bot_next[c] = 17'(in_req.p01[8*c +: 8] * wx)
                        + 17'(in_req.p11[8*c +: 8] * {1'b0, in_req.fx});
        end
    end

    // Vertical blend and rounding
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            vsum[c] = 26'(top_reg[c] * wy) + 26'(bot_reg[c] * {1'b0, b1fy_reg}) + ROUND_HALF;
            ch[c]   = vsum[c][23:16];
        end
        b2_next.col   = b1col_reg;
        b2_next.row   = b1row_reg;
        b2_next.color = b1near_reg ? b1word_reg : {8'h00, ch[2], ch[1], ch[0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1v_reg <= 1'b0;
            b2v_reg <= 1'b0;
        end else if (en) begin
            b1v_reg <= in_valid;
            b2v_reg <= b1v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1near_reg <= in_req.near;
            b1word_reg <= in_req.p11;
            b1fy_reg   <= in_req.fy;
            b1col_reg  <= in_req.col;
            b1row_reg  <= in_req.row;
            for (int c = 0; c < 3; c++) begin
                top_reg[c] <= top_next[c];
                bot_reg[c] <= bot_next[c];
            end
            b2_reg <= b2_next;
        end
    end

    assign out_valid = b2v_reg;
    assign out_pix   = b2_reg;

endmodule

>>> hw/rtl/image_scaler_nearest_bilinear_core.sv
// Image scaler core: source image memory, nearest and bilinear destination pixels.
// Depends on imsc_pkg, imsc_div and imsc_blend.
//
//   channel | direction | handshake            | words
//   s_      | in        | s_valid / s_ready    | load pixel or request pixel
//   m_      | out       | m_valid / m_ready    | canvas position and color
//   cfg_    | in        | cfg_we               | one register per write
//
// A load or a nearest request takes one access of the source memory port, a
// bilinear request four (one read per neighbor), so while the output buffer has
// room loads and nearest requests are accepted one per cycle and a bilinear one
// holds the input until its last read. Each word passes the clip, numerator and
// divider stages, QW being the quotient width of the divider pipeline.
// Reset is synchronous and clears control only; the memory is not cleared.
// A two-word output buffer keeps the input open while a result waits.
module image_scaler_nearest_bilinear_core
    import imsc_pkg::*;
#(
    parameter int SRC_MAX_W = 64,
    parameter int SRC_MAX_H = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [11:0] s_col,
    input  logic [11:0] s_row,
    input  logic [31:0] s_pixel_in,
    input  logic        s_bilinear,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_out_col,
    output logic [11:0] m_out_row,
    output logic [31:0] m_color
);

    localparam int XW    = (SRC_MAX_W > 1) ? $clog2(SRC_MAX_W) : 1;
    localparam int YW    = (SRC_MAX_H > 1) ? $clog2(SRC_MAX_H) : 1;
    localparam int DEPTH = SRC_MAX_W * SRC_MAX_H;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DMAX  = (SRC_MAX_W > SRC_MAX_H) ? SRC_MAX_W : SRC_MAX_H;
    localparam int DCAP  = (DMAX > 127) ? 127 : DMAX;
    localparam int QW    = 8 + $clog2(DCAP + 1);
    localparam int HW    = QW - 7;
    localparam int PW    = $bits(item_t);

    // Configuration registers
    logic [6:0]         src_w_reg, src_h_reg;
    logic signed [12:0] tgt_l_reg, tgt_t_reg;
    logic [12:0]        tgt_w_reg, tgt_h_reg, cnv_w_reg, cnv_h_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= '0;
            src_h_reg <= '0;
            tgt_l_reg <= '0;
            tgt_t_reg <= '0;
            tgt_w_reg <= '0;
            tgt_h_reg <= '0;
            cnv_w_reg <= '0;
            cnv_h_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SRC_W: src_w_reg <= cfg_data[6:0];
                CFG_SRC_H: src_h_reg <= cfg_data[6:0];
                CFG_TGT_L: tgt_l_reg <= $signed(cfg_data);
                CFG_TGT_T: tgt_t_reg <= $signed(cfg_data);
                CFG_TGT_W: tgt_w_reg <= cfg_data;
                CFG_TGT_H: tgt_h_reg <= cfg_data;
                CFG_CNV_W: cnv_w_reg <= cfg_data;
                CFG_CNV_H: cnv_h_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Global stall and front shift
    logic [1:0] fifo_cnt_reg;
    logic       go, shift, mem_free, mem_last;

    assign go      = fifo_cnt_reg != 2'd2;
    assign shift   = go && mem_free;
    assign s_ready = shift;

    // Stage 0: input word
    logic        v0_reg, k0_reg, b0_reg;
    logic [11:0] c0_reg, r0_reg;
    logic [31:0] p0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (shift) begin
            v0_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            k0_reg <= s_kind;
            b0_reg <= s_bilinear;
            c0_reg <= s_col;
            r0_reg <= s_row;
            p0_reg <= s_pixel_in;
        end
    end

    // Stage 1: clip against rectangle and canvas, check load bounds, offsets in the rectangle
    logic [6:0]         sw_eff, sh_eff;
    logic signed [14:0] col_s, row_s, left_s, top_s, right_s, bottom_s;
    logic               in_x, in_y, sizes_ok, ld_ok;
    item_t              it1_next, it1_reg;
    logic               v1_reg;
    logic [12:0]        dx1_reg, dy1_reg;

    always_comb begin
        sw_eff   = (int'(src_w_reg) > SRC_MAX_W) ? 7'(SRC_MAX_W) : src_w_reg;
        sh_eff   = (int'(src_h_reg) > SRC_MAX_H) ? 7'(SRC_MAX_H) : src_h_reg;
        col_s    = $signed({3'b000, c0_reg});
        row_s    = $signed({3'b000, r0_reg});
        left_s   = {{2{tgt_l_reg[12]}}, tgt_l_reg};
        top_s    = {{2{tgt_t_reg[12]}}, tgt_t_reg};
        right_s  = left_s + $signed({2'b00, tgt_w_reg});
        bottom_s = top_s + $signed({2'b00, tgt_h_reg});
        in_x     = (col_s >= left_s) && (col_s < right_s) && ({1'b0, c0_reg} < cnv_w_reg);
        in_y     = (row_s >= top_s) && (row_s < bottom_s) && ({1'b0, r0_reg} < cnv_h_reg);
        sizes_ok = (sw_eff != '0) && (sh_eff != '0) && (tgt_w_reg != '0) && (tgt_h_reg != '0);
        ld_ok    = (int'(c0_reg) < SRC_MAX_W) && (int'(r0_reg) < SRC_MAX_H);

        it1_next.kind = k0_reg;
        it1_next.bil  = b0_reg;
        it1_next.act  = (k0_reg == KIND_REQ) ? (sizes_ok && in_x && in_y) : ld_ok;
        it1_next.col  = c0_reg;
        it1_next.row  = r0_reg;
        it1_next.pix  = p0_reg;
        it1_next.sw   = sw_eff;
        it1_next.sh   = sh_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (shift) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            it1_reg <= it1_next;
            dx1_reg <= 13'(col_s - left_s);
            dy1_reg <= 13'(row_s - top_s);
        end
    end

    // Stage 2: numerators, d*S for nearest, 128*(2d+1)*S for bilinear
    logic [20:0]       mx, my;
    logic [NUM_W-1:0]  nx_reg, ny_reg;
    item_t             it2_reg;
    logic              v2_reg;

    assign mx = it1_reg.bil ? 21'({dx1_reg, 1'b1} * it1_reg.sw)
                            : 21'({1'b0, dx1_reg} * it1_reg.sw);
    assign my = it1_reg.bil ? 21'({dy1_reg, 1'b1} * it1_reg.sh)
                            : 21'({1'b0, dy1_reg} * it1_reg.sh);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (shift) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            it2_reg <= it1_reg;
            nx_reg  <= it1_reg.bil ? {mx, 7'b0} : {7'b0, mx};
            ny_reg  <= it1_reg.bil ? {my, 7'b0} : {7'b0, my};
        end
    end

    // Quotients by the rectangle size
    logic          v3;
    logic [QW-1:0] qx, qy;
    logic [PW-1:0] pay3;
    item_t         it3;

    imsc_div #(
        .QW (QW),
        .NW (NUM_W),
        .DW (13),
        .PW (PW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (shift),
        .in_valid  (v2_reg),
        .in_nx     (nx_reg),
        .in_ny     (ny_reg),
        .den_x     (tgt_w_reg),
        .den_y     (tgt_h_reg),
        .in_pay    (PW'(it2_reg)),
        .out_valid (v3),
        .out_qx    (qx),
        .out_qy    (qy),
        .out_pay   (pay3)
    );

    assign it3 = item_t'(pay3);

    // Source coordinates from quotients, clamped to the source edge
    logic [HW-1:0] hx, hy, smx, smy, ix0, ix1, iy0, iy1;
    logic [QW-1:0] snx, sny;
    logic [XW-1:0] x0, x1;
    logic [YW-1:0] y0, y1;
    logic [7:0]    fx3, fy3;
    logic          negx, negy;

    function automatic logic [AW-1:0] addr_of(input logic [YW-1:0] y, input logic [XW-1:0] x);
        return AW'(int'(y) * SRC_MAX_W + int'(x));
    endfunction

    always_comb begin
        hx   = {1'b0, qx[QW-1:8]};
        hy   = {1'b0, qy[QW-1:8]};
        smx  = HW'(it3.sw) - 1'b1;
        smy  = HW'(it3.sh) - 1'b1;
        negx = (qx[QW-1:8] == '0) && !qx[7];
        negy = (qy[QW-1:8] == '0) && !qy[7];
        ix0  = hx - HW'(!qx[7]);
        iy0  = hy - HW'(!qy[7]);
        ix1  = hx + HW'(qx[7]);
        iy1  = hy + HW'(qy[7]);
        snx  = QW'(it3.sw) - 1'b1;
        sny  = QW'(it3.sh) - 1'b1;
        fx3  = qx[7:0] ^ 8'h80;
        fy3  = qy[7:0] ^ 8'h80;
        if (it3.kind == KIND_LOAD) begin
            x0 = XW'(it3.col);
            y0 = YW'(it3.row);
            x1 = x0;
            y1 = y0;
        end else if (!it3.bil) begin
            x0 = (qx > snx) ? XW'(snx) : XW'(qx);
            y0 = (qy > sny) ? YW'(sny) : YW'(qy);
            x1 = x0;
            y1 = y0;
        end else begin
            x0 = negx ? '0 : ((ix0 > smx) ? XW'(smx) : XW'(ix0));
            y0 = negy ? '0 : ((iy0 > smy) ? YW'(smy) : YW'(iy0));
            x1 = (ix1 > smx) ? XW'(smx) : XW'(ix1);
            y1 = (iy1 > smy) ? YW'(smy) : YW'(iy1);
        end
    end

    // Memory sequencer: one access per cycle while not stalled, four reads for bilinear
    logic          mv_reg, mreq_reg, mwr_reg, mbil_reg;
    logic [1:0]    mcnt_reg, mlast_reg;
    logic [AW-1:0] maddr_reg [4];
    logic [31:0]   mpix_reg;
    logic [7:0]    mfx_reg, mfy_reg;
    logic [11:0]   mcol_reg, mrow_reg;
    logic [AW-1:0] raddr;

    assign mem_last = mcnt_reg == mlast_reg;
    assign mem_free = !mv_reg || mem_last;
    assign raddr    = maddr_reg[mcnt_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg   <= 1'b0;
            mcnt_reg <= '0;
        end else if (go) begin
            if (mem_free) begin
                mv_reg   <= v3;
                mcnt_reg <= '0;
            end else begin
                mcnt_reg <= mcnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            mreq_reg     <= (it3.kind == KIND_REQ) && it3.act;
            mwr_reg      <= (it3.kind == KIND_LOAD) && it3.act;
            mbil_reg     <= it3.bil;
            mlast_reg    <= ((it3.kind == KIND_REQ) && it3.act && it3.bil) ? 2'd3 : 2'd0;
            maddr_reg[0] <= addr_of(y0, x0);
            maddr_reg[1] <= addr_of(y0, x1);
            maddr_reg[2] <= addr_of(y1, x0);
            maddr_reg[3] <= addr_of(y1, x1);
            mpix_reg     <= it3.pix;
            mfx_reg      <= fx3;
            mfy_reg      <= fy3;
            mcol_reg     <= it3.col;
            mrow_reg     <= it3.row;
        end
    end

    // Source image memory
    logic [31:0] src_mem [DEPTH];
    logic [31:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (go && mv_reg && mwr_reg) begin
            src_mem[maddr_reg[0]] <= mpix_reg;
        end
        if (go) begin
            rd_reg <= src_mem[raddr];
        end
    end

    // Tag travelling with the read data
    logic        tv_reg, tlast_reg, tbil_reg;
    logic [1:0]  tidx_reg;
    logic [7:0]  tfx_reg, tfy_reg;
    logic [11:0] tcol_reg, trow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tv_reg <= 1'b0;
        end else if (go) begin
            tv_reg <= mv_reg && mreq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            tlast_reg <= mem_last;
            tidx_reg  <= mcnt_reg;
            tbil_reg  <= mbil_reg;
            tfx_reg   <= mfx_reg;
            tfy_reg   <= mfy_reg;
            tcol_reg  <= mcol_reg;
            trow_reg  <= mrow_reg;
        end
    end

    // Collect the first three neighbors
    logic [31:0] c00_reg, c10_reg, c01_reg;

    always_ff @(posedge aclk) begin
        if (go && tv_reg) begin
            case (tidx_reg)
                2'd0:    c00_reg <= rd_reg;
                2'd1:    c10_reg <= rd_reg;
                2'd2:    c01_reg <= rd_reg;
                default: ;
            endcase
        end
    end

    blend_req_t breq;
    logic       bo_valid;
    pix_out_t   bo_pix;

    always_comb begin
        breq.near = !tbil_reg;
        breq.fx   = tfx_reg;
        breq.fy   = tfy_reg;
        breq.p00  = c00_reg;
        breq.p10  = c10_reg;
        breq.p01  = c01_reg;
        breq.p11  = rd_reg;
        breq.col  = tcol_reg;
        breq.row  = trow_reg;
    end

    imsc_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (go),
        .in_valid  (tv_reg && tlast_reg),
        .in_req    (breq),
        .out_valid (bo_valid),
        .out_pix   (bo_pix)
    );

    // Two-word output buffer
    pix_out_t ent_reg [2];
    logic     wp_reg, rp_reg;
    logic     push, pop;

    assign push = go && bo_valid;
    assign pop  = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= 1'b0;
            rp_reg       <= 1'b0;
            fifo_cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= !wp_reg;
            end
            if (pop) begin
                rp_reg <= !rp_reg;
            end
            fifo_cnt_reg <= fifo_cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= bo_pix;
        end
    end

    assign m_valid   = fifo_cnt_reg != 2'd0;
    assign m_out_col = ent_reg[rp_reg].col;
    assign m_out_row = ent_reg[rp_reg].row;
    assign m_color   = ent_reg[rp_reg].color;

    // Checks
    a_fifo_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fifo_cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_ready_room: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (fifo_cnt_reg != 2'd2))
        else $error("input taken while output buffer full");

    a_seq_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        mv_reg |-> (mcnt_reg <= mlast_reg))
        else $error("memory sequencer ran past last read");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!go && mv_reg) |=> ($stable(mcnt_reg) && mv_reg))
        else $error("memory sequencer moved while stalled");

endmodule

>>> tb/sv/tb_image_scaler_nearest_bilinear_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for image_scaler_nearest_bilinear_core: loads source
// images, requests canvas pixels and checks every result. Depends on imsc_pkg.
module tb_image_scaler_nearest_bilinear_core;
    import imsc_pkg::*;

    localparam int MAX_W      = 64;
    localparam int MAX_H      = 64;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 120;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic        s_kind;
    logic [11:0] s_col;
    logic [11:0] s_row;
    logic [31:0] s_pixel_in;
    logic        s_bilinear;
    logic        m_valid;
    logic        m_ready;
    logic [11:0] m_out_col;
    logic [11:0] m_out_row;
    logic [31:0] m_color;

    image_scaler_nearest_bilinear_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind), .s_col(s_col),
        .s_row(s_row), .s_pixel_in(s_pixel_in), .s_bilinear(s_bilinear),
        .m_valid(m_valid), .m_ready(m_ready), .m_out_col(m_out_col),
        .m_out_row(m_out_row), .m_color(m_color)
    );

    // Scaler state as the testbench sees it
    logic [31:0] src_pixels [MAX_W*MAX_H];
    logic [6:0]  src_w, src_h;
    int          tgt_l, tgt_t;
    int          tgt_w, tgt_h, cnv_w, cnv_h;

    pix_out_t    expected_pixels[$];
    int          error_count = 0;
    int          pixels_checked = 0;
    int          words_sent = 0;
    bit          steady = 0;      // no idling on either side
    int          hold_request = 0;
    int          hold_left = 0;
    int          idle_cycles = 0;

    always begin
        aclk = 1'b0; #5;
        aclk = 1'b1; #5;
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic longint floor_div(input longint num, input longint den);
        if (num >= 0) return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic longint clamp_to(input longint v, input longint hi);
        return v < 0 ? 0 : (v > hi ? hi : v);
    endfunction

    function automatic logic [7:0] mix_channel(input logic [31:0] a, b, c, d,
                                               input int fx, fy, sh);
        int unsigned top, bot, v;
        top = ((a >> sh) & 8'hFF) * (256 - fx) + ((b >> sh) & 8'hFF) * fx;
        bot = ((c >> sh) & 8'hFF) * (256 - fx) + ((d >> sh) & 8'hFF) * fx;
        v = top * (256 - fy) + bot * fy;
        return 8'((v + 32768) >> 16);
    endfunction

    // Update the source image or compute the pixel a request should return
    function automatic bit scale_pixel(input logic kind, input logic [11:0] col, row,
                                       input logic [31:0] pix, input logic bil,
                                       output pix_out_t res);
        longint sw, sh, dx, dy, px, py, x0, x1, y0, y1;
        longint ci, ri;
        int fx, fy;
        logic [31:0] p00, p10, p01, p11;
        res = '0;
        ci = col;
        ri = row;
        if (kind == KIND_LOAD) begin
            if (ci < MAX_W && ri < MAX_H) src_pixels[ri*MAX_W + ci] = pix;
            return 0;
        end
        sw = src_w > MAX_W ? MAX_W : src_w;
        sh = src_h > MAX_H ? MAX_H : src_h;
        if (sw == 0 || sh == 0 || tgt_w == 0 || tgt_h == 0) return 0;
        if (ci < tgt_l || ci >= tgt_l + tgt_w || ci >= cnv_w) return 0;
        if (ri < tgt_t || ri >= tgt_t + tgt_h || ri >= cnv_h) return 0;
        dx = ci - tgt_l;
        dy = ri - tgt_t;
        res.col = col;
        res.row = row;
        if (!bil) begin
            x0 = clamp_to(dx * sw / tgt_w, sw - 1);
            y0 = clamp_to(dy * sh / tgt_h, sh - 1);
            res.color = src_pixels[y0*MAX_W + x0];
        end else begin
            px = floor_div(256 * ((2*dx + 1) * sw - tgt_w), 2 * tgt_w);
            py = floor_div(256 * ((2*dy + 1) * sh - tgt_h), 2 * tgt_h);
            fx = int'(px & 255);
            fy = int'(py & 255);
            x0 = clamp_to(px >>> 8, sw - 1);
            x1 = clamp_to((px >>> 8) + 1, sw - 1);
            y0 = clamp_to(py >>> 8, sh - 1);
            y1 = clamp_to((py >>> 8) + 1, sh - 1);
            p00 = src_pixels[y0*MAX_W + x0];
            p10 = src_pixels[y0*MAX_W + x1];
            p01 = src_pixels[y1*MAX_W + x0];
            p11 = src_pixels[y1*MAX_W + x1];
            res.color = {8'h00, mix_channel(p00, p10, p01, p11, fx, fy, 16),
                         mix_channel(p00, p10, p01, p11, fx, fy, 8),
                         mix_channel(p00, p10, p01, p11, fx, fy, 0)};
        end
        return 1;
    endfunction

    // Offer one word, hold it until accepted, then record its expected pixel
    task automatic send_word(input logic kind, input logic [11:0] col, row,
                             input logic [31:0] pix, input logic bil);
        pix_out_t res;
        if (!steady && $urandom_range(0, 99) < 33) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_kind     <= kind;
        s_col      <= col;
        s_row      <= row;
        s_pixel_in <= pix;
        s_bilinear <= bil;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
        if (scale_pixel(kind, col, row, pix, bil, res)) expected_pixels.push_back(res);
    endtask

    // Drop valid and wait until every pixel is back and the pipeline is empty
    task automatic drain;
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write all registers back to back; only called while idle
    task automatic set_config(input int sw, sh, l, t, w, h, cw, ch);
        int vals[8];
        vals = '{sw, sh, l, t, w, h, cw, ch};
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= 13'(vals[i]);
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        src_w = 7'(sw);
        src_h = 7'(sh);
        tgt_l = $signed(13'(l));
        tgt_t = $signed(13'(t));
        tgt_w = w & 32'h1FFF;
        tgt_h = h & 32'h1FFF;
        cnv_w = cw & 32'h1FFF;
        cnv_h = ch & 32'h1FFF;
    endtask

    // Fill the whole clamped source area so no request reads an empty entry
    task automatic load_source;
        int w, h;
        w = src_w > MAX_W ? MAX_W : src_w;
        h = src_h > MAX_H ? MAX_H : src_h;
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                send_word(KIND_LOAD, 12'(x), 12'(y), $urandom, $urandom_range(0, 1));
    endtask

    // Pick a coordinate near the target span, sometimes anywhere
    function automatic logic [11:0] near_span(input int lo, input int len);
        int v;
        if ($urandom_range(0, 9) == 0) return 12'($urandom);
        v = lo + $urandom_range(0, len + 3) - 2;
        return 12'(clamp_to(v, 4095));
    endfunction

    task automatic send_request(input logic bil);
        send_word(KIND_REQ, near_span(tgt_l, tgt_w), near_span(tgt_t, tgt_h),
                  $urandom, bil);
    endtask

    task automatic test_directed;
        set_config(4, 3, 2, 1, 9, 7, 10, 7);
        send_word(KIND_LOAD, 0, 0, 32'hFFFF_FFFF, 1);
        send_word(KIND_LOAD, 1, 0, 32'h0000_0000, 0);
        send_word(KIND_LOAD, 12'hFFF, 12'hFFF, 32'h1234_5678, 0);   // ignored
        send_word(KIND_LOAD, 64, 0, 32'hDEAD_BEEF, 0);              // ignored
        load_source();
        send_word(KIND_LOAD, 0, 0, 32'hFF00_FF00, 0);
        send_word(KIND_REQ, 2, 1, 32'hFFFF_FFFF, 0);     // top-left, nearest
        send_word(KIND_REQ, 2, 1, 0, 1);                 // centre above/left of source
        send_word(KIND_REQ, 9, 6, 0, 1);                 // bottom-right corner
        send_word(KIND_REQ, 9, 6, 0, 0);
        send_word(KIND_REQ, 5, 3, 0, 1);
        send_word(KIND_REQ, 1, 3, 0, 0);                 // left of target
        send_word(KIND_REQ, 5, 0, 0, 1);                 // above target
        send_word(KIND_REQ, 10, 3, 0, 0);                // clipped by canvas
        send_word(KIND_REQ, 12'hFFF, 12'hFFF, 0, 1);
        drain();
        // Zero sizes give nothing
        set_config(4, 3, 0, 0, 0, 7, 10, 7);
        send_word(KIND_REQ, 0, 0, 0, 0);
        drain();
        set_config(0, 3, 0, 0, 9, 7, 10, 7);
        send_word(KIND_REQ, 1, 1, 0, 1);
        drain();
        set_config(4, 0, 0, 0, 9, 0, 10, 7);
        send_word(KIND_REQ, 1, 1, 0, 0);
        drain();
    endtask

    task automatic test_extremes;
        // Oversized width saturates; full-size canvas and target
        set_config(127, 1, -100, -4096, 4096, 8191, 4096, 4096);
        load_source();
        repeat (12) send_word(KIND_REQ, 12'($urandom), 12'($urandom), 0, $urandom_range(0, 1));
        send_word(KIND_REQ, 0, 0, 0, 1);
        send_word(KIND_REQ, 12'hFFF, 12'hFFF, 0, 0);
        drain();
        set_config(1, 127, 4095, 4095, 1, 1, 4096, 4096);
        load_source();
        send_word(KIND_REQ, 12'hFFF, 12'hFFF, 0, 1);
        send_word(KIND_REQ, 12'hFFF, 12'hFFF, 0, 0);
        send_word(KIND_REQ, 12'hFFE, 12'hFFF, 0, 0);
        drain();
        set_config(64, 64, 0, 0, 1, 1, 1, 1);    // shrink a large source to one pixel
        send_word(KIND_REQ, 0, 0, 0, 0);
        drain();
    endtask

    task automatic test_random;
        for (int ph = 0; ph < 5; ph++) begin
            steady = (ph == 2);
            set_config($urandom_range(1, 6), $urandom_range(1, 6),
                       $urandom_range(0, 40) - 8, $urandom_range(0, 40) - 8,
                       $urandom_range(1, 24), $urandom_range(1, 24),
                       $urandom_range(0, 50), $urandom_range(0, 50));
            load_source();
            repeat (60) begin
                if ($urandom_range(0, 9) == 0)
                    send_word(KIND_LOAD, 12'($urandom_range(0, 5)),
                              12'($urandom_range(0, 5)), $urandom, $urandom_range(0, 1));
                else if ($urandom_range(0, 19) == 0)
                    send_word(KIND_LOAD, 12'($urandom), 12'($urandom | 64), $urandom, 0);
                else
                    send_request($urandom_range(0, 1));
            end
            drain();
        end
        steady = 0;
    endtask

    task automatic test_backpressure;
        set_config(5, 4, 3, 3, 16, 12, 40, 40);
        load_source();
        hold_request = 400;
        repeat (60) send_word(KIND_REQ, 12'($urandom_range(3, 18)),
                              12'($urandom_range(3, 14)), 0, $urandom_range(0, 1));
        drain();
    endtask

    // Receiver: random stalls, a steady stretch and a long hold-off
    always @(posedge aclk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(0, 99) >= 33);
        end
    end

    // Compare each accepted pixel with the oldest expectation
    always @(posedge aclk) begin
        pix_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                flag_mismatch($sformatf("unexpected pixel (%0d,%0d) %h",
                                        m_out_col, m_out_row, m_color));
            end else begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (m_out_col !== want.col || m_out_row !== want.row ||
                    m_color !== want.color)
                    flag_mismatch($sformatf("got (%0d,%0d) %h, want (%0d,%0d) %h",
                                            m_out_col, m_out_row, m_color,
                                            want.col, want.row, want.color));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("tb_image_scaler_nearest_bilinear_core: errors");
            $finish;
        end
    end

    initial begin
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        s_valid    = 1'b0;
        s_kind     = KIND_LOAD;
        s_col      = '0;
        s_row      = '0;
        s_pixel_in = '0;
        s_bilinear = 1'b0;
        m_ready    = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_extremes();
        test_random();
        test_backpressure();
        if (expected_pixels.size() != 0)
            flag_mismatch($sformatf("%0d pixels never arrived", expected_pixels.size()));
        $display("Sent %0d words (loads, requests, nearest and bilinear, clipped and",
                 words_sent);
        $display("zero-size cases, long output stall); checked %0d pixels.", pixels_checked);
        if (error_count == 0)
            $display("tb_image_scaler_nearest_bilinear_core: clean");
        else
            $display("tb_image_scaler_nearest_bilinear_core: errors");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/imsc_pkg.sv
hw/rtl/imsc_div.sv
hw/rtl/imsc_blend.sv
hw/rtl/image_scaler_nearest_bilinear_core.sv
tb/sv/tb_image_scaler_nearest_bilinear_core.sv
